### sv/ffc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Flat-field correction package
// Payload types, configuration register codes and fixed constants shared by
// the pipeline stages of the flat-field correction block.
// ---------------------------------------------------------------------------
package ffc_pkg;

  // Width of the fixed-point result field.
  localparam int OutBits = 33;
  // Quotient bits produced by each divider stage.
  localparam int DivStepsPerStage = 4;

  typedef enum logic [1:0] {
    RegFlatPresent     = 2'd0,
    RegDarkPresent     = 2'd1,
    RegFlatDarkPresent = 2'd2,
    RegMaskPresent     = 2'd3
  } ffc_reg_e;

  typedef struct packed {
    logic [15:0] raw_pixel;
    logic [15:0] dark_pixel;
    logic [15:0] flat_pixel;
    logic [15:0] flat_dark_pixel;
    logic        mask_keep;
  } ffc_in_t;

  typedef struct packed {
    logic signed [OutBits-1:0] corrected;
    logic                      gain_zero;
  } ffc_out_t;

  typedef struct packed {
    logic flat_present;
    logic dark_present;
    logic flat_dark_present;
    logic mask_present;
  } ffc_cfg_t;

  // Control that travels alongside the operands through every stage.
  typedef struct packed {
    logic valid;
    logic neg;
    logic gain_zero;
  } ffc_ctl_t;

endpackage

### sv/ffc_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Flat-field correction operand stage
// Forms the signed numerator and denominator, the sign of the result, the
// masked/zero-gain flag and the divider operands.
// ---------------------------------------------------------------------------
module ffc_front #(
  parameter int PIXEL_BITS = 16,
  parameter int FRAC_BITS  = 16,
  parameter int QUO_BITS   = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  ffc_pkg::ffc_in_t        in_i,
  input  ffc_pkg::ffc_cfg_t       cfg_i,
  output ffc_pkg::ffc_ctl_t       ctl_o,
  output logic [PIXEL_BITS-1:0]   dvsr_o,
  output logic [QUO_BITS-1:0]     dvnd_o
);

  logic [PIXEL_BITS-1:0] raw, dark, flat, fdark;
  logic [PIXEL_BITS:0]   num, den;
  logic [PIXEL_BITS-1:0] num_mag, den_mag;
  logic                  num_neg, den_neg, zero_gain;
  ffc_pkg::ffc_ctl_t     ctl_d, ctl_q;
  logic [PIXEL_BITS-1:0] dvsr_d, dvsr_q;
  logic [QUO_BITS-1:0]   dvnd_d, dvnd_q;

  assign raw   = PIXEL_BITS'(in_i.raw_pixel);
  assign dark  = PIXEL_BITS'(in_i.dark_pixel);
  assign flat  = PIXEL_BITS'(in_i.flat_pixel);
  assign fdark = PIXEL_BITS'(in_i.flat_dark_pixel);

  always_comb begin
    num = cfg_i.dark_present ? ({1'b0, raw} - {1'b0, dark}) : {1'b0, raw};
    if (cfg_i.flat_dark_present) begin
      den = {1'b0, flat} - {1'b0, fdark};
    end else if (cfg_i.dark_present) begin
      den = {1'b0, flat} - {1'b0, dark};
    end else begin
      den = {1'b0, flat};
    end
    num_neg = num[PIXEL_BITS];
    den_neg = den[PIXEL_BITS];
    num_mag = num_neg ? PIXEL_BITS'(-num) : num[PIXEL_BITS-1:0];
    den_mag = den_neg ? PIXEL_BITS'(-den) : den[PIXEL_BITS-1:0];
    zero_gain = cfg_i.flat_present &&
                ((cfg_i.mask_present && !in_i.mask_keep) || (den == '0));

    // Without a flat, or when the result is forced to zero, divide by one.
    if (!cfg_i.flat_present || zero_gain) begin
      dvsr_d = PIXEL_BITS'(1);
    end else begin
      dvsr_d = den_mag;
    end
    dvnd_d = QUO_BITS'({num_mag, {FRAC_BITS{1'b0}}});
    if (zero_gain) begin
      dvnd_d = '0;
    end

    ctl_d.valid     = valid_i;
    ctl_d.neg       = num_neg ^ (cfg_i.flat_present & den_neg);
    ctl_d.gain_zero = zero_gain;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvsr_q <= dvsr_d;
      dvnd_q <= dvnd_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign dvsr_o = dvsr_q;
  assign dvnd_o = dvnd_q;

endmodule

### sv/ffc_div_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Flat-field correction divider stage
// One registered slice of a restoring divider that retires a fixed number
// of quotient bits per stage.
// ---------------------------------------------------------------------------
module ffc_div_stage #(
  parameter int PIXEL_BITS = 16,
  parameter int QUO_BITS   = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  ffc_pkg::ffc_ctl_t     ctl_i,
  input  logic [PIXEL_BITS-1:0] dvsr_i,
  input  logic [PIXEL_BITS-1:0] rem_i,
  input  logic [QUO_BITS-1:0]   quo_i,
  output ffc_pkg::ffc_ctl_t     ctl_o,
  output logic [PIXEL_BITS-1:0] dvsr_o,
  output logic [PIXEL_BITS-1:0] rem_o,
  output logic [QUO_BITS-1:0]   quo_o
);

  ffc_pkg::ffc_ctl_t     ctl_q;
  logic [PIXEL_BITS-1:0] dvsr_q;
  logic [PIXEL_BITS-1:0] rem_d, rem_q;
  logic [QUO_BITS-1:0]   quo_d, quo_q;
  logic [PIXEL_BITS:0]   trial;

  // The shift register holds the unconsumed dividend bits at the top and
  // collects quotient bits at the bottom.
  always_comb begin
    rem_d = rem_i;
    quo_d = quo_i;
    trial = '0;
    for (int s = 0; s < ffc_pkg::DivStepsPerStage; s++) begin
      trial = {rem_d, quo_d[QUO_BITS-1]};
      quo_d = {quo_d[QUO_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dvsr_i}) begin
        rem_d    = PIXEL_BITS'(trial - {1'b0, dvsr_i});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[PIXEL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvsr_q <= dvsr_i;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign dvsr_o = dvsr_q;
  assign rem_o  = rem_q;
  assign quo_o  = quo_q;

endmodule

### sv/ffc_pack.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Flat-field correction output stage
// Applies the sign, saturates to the signed result range and holds the
// result transaction until the receiver takes it.
// ---------------------------------------------------------------------------
module ffc_pack #(
  parameter int QUO_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  ffc_pkg::ffc_ctl_t   ctl_i,
  input  logic [QUO_BITS-1:0] quo_i,
  output logic                valid_o,
  output ffc_pkg::ffc_out_t   out_o
);

  localparam int ExtBits = (QUO_BITS > ffc_pkg::OutBits) ? QUO_BITS : ffc_pkg::OutBits + 1;
  localparam logic [ExtBits-1:0] PosLimit = ExtBits'(34'h0_FFFF_FFFF);
  localparam logic [ExtBits-1:0] NegLimit = ExtBits'(34'h1_0000_0000);

  logic [ExtBits-1:0] quo_ext, lim, mag, signed_mag;
  logic               neg;
  ffc_pkg::ffc_out_t  out_d, out_q;
  logic               valid_q;

  always_comb begin
    quo_ext    = ExtBits'(quo_i);
    neg        = ctl_i.neg && (quo_i != '0);
    lim        = neg ? NegLimit : PosLimit;
    mag        = (quo_ext > lim) ? lim : quo_ext;
    signed_mag = neg ? (~mag + ExtBits'(1)) : mag;
    out_d.corrected = signed_mag[ffc_pkg::OutBits-1:0];
    out_d.gain_zero = ctl_i.gain_zero;
    if (ctl_i.gain_zero) begin
      out_d.corrected = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q;
  assign out_o   = out_q;

endmodule

### sv/flat_field_correction.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Flat-field correction
// Per-pixel dark subtraction and flat-field gain in signed fixed point.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one pixel with
//   its dark, flat, flat-dark and mask samples per transaction. The output
//   channel (out_valid_o / out_stall_i / out_data_o) returns one corrected
//   pixel per input, in order.
//   The four presence registers are to be written through cfg_we_i, cfg_idx_i
//   and cfg_wdata_i only while the pipeline is empty; the block itself does not
//   enforce this. They reset to zero. Throughput is one pixel per clock while
//   the output is not stalled. The pipeline has one operand stage, one
//   restoring divider stage per four quotient bits, and one saturation and
//   output register stage.
//   Reset empties the pipeline; nothing is held over.
//   When the receiver stalls, the output register holds its transaction and
//   stages behind it keep moving until they run into a full stage, so
//   bubbles are squeezed out. in_stall_o rises only once every stage is full
//   and the output is stalled.
// ---------------------------------------------------------------------------
module flat_field_correction #(
  parameter int PIXEL_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ffc_pkg::ffc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ffc_pkg::ffc_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic              cfg_wdata_i
);

  localparam int QuoWidth  = PIXEL_BITS + FRAC_BITS;
  localparam int DivStages = (QuoWidth + ffc_pkg::DivStepsPerStage - 1) /
                             ffc_pkg::DivStepsPerStage;
  localparam int QuoBits   = DivStages * ffc_pkg::DivStepsPerStage;

  ffc_pkg::ffc_cfg_t     cfg_q;
  ffc_pkg::ffc_ctl_t     ctl  [DivStages+1];
  logic [PIXEL_BITS-1:0] dvsr [DivStages+1];
  logic [PIXEL_BITS-1:0] rem  [DivStages+1];
  logic [QuoBits-1:0]    quo  [DivStages+1];
  // Stage enables: operand stage, divider stages, output stage.
  logic [DivStages+1:0]  en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (ffc_pkg::ffc_reg_e'(cfg_idx_i))
        ffc_pkg::RegFlatPresent:     cfg_q.flat_present      <= cfg_wdata_i;
        ffc_pkg::RegDarkPresent:     cfg_q.dark_present      <= cfg_wdata_i;
        ffc_pkg::RegFlatDarkPresent: cfg_q.flat_dark_present <= cfg_wdata_i;
        ffc_pkg::RegMaskPresent:     cfg_q.mask_present      <= cfg_wdata_i;
        default:                     cfg_q                   <= cfg_q;
      endcase
    end
  end

  // A stage loads when it is empty or its contents move on this cycle.
  assign en[DivStages+1] = !out_valid_o || !out_stall_i;
  for (genvar k = 0; k <= DivStages; k++) begin : g_en
    assign en[k] = !ctl[k].valid || en[k+1];
  end
  assign in_stall_o = !en[0];

  ffc_front #(
    .PIXEL_BITS (PIXEL_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .QUO_BITS   (QuoBits)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[0]),
    .valid_i (in_valid_i),
    .in_i    (in_data_i),
    .cfg_i   (cfg_q),
    .ctl_o   (ctl[0]),
    .dvsr_o  (dvsr[0]),
    .dvnd_o  (quo[0])
  );
  assign rem[0] = '0;

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    ffc_div_stage #(
      .PIXEL_BITS (PIXEL_BITS),
      .QUO_BITS   (QuoBits)
    ) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en[s+1]),
      .ctl_i  (ctl[s]),
      .dvsr_i (dvsr[s]),
      .rem_i  (rem[s]),
      .quo_i  (quo[s]),
      .ctl_o  (ctl[s+1]),
      .dvsr_o (dvsr[s+1]),
      .rem_o  (rem[s+1]),
      .quo_o  (quo[s+1])
    );
  end

  ffc_pack #(
    .QUO_BITS (QuoBits)
  ) u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[DivStages+1]),
    .ctl_i   (ctl[DivStages]),
    .quo_i   (quo[DivStages]),
    .valid_o (out_valid_o),
    .out_o   (out_data_o)
  );

  // A forced-zero pixel never carries a non-zero value.
  a_zero_gain_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.gain_zero |-> out_data_o.corrected == '0)
    else $error("gain_zero result with non-zero corrected value");

  // Back-pressure only comes from a stalled, occupied output register.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output is free");

  // A stalled output transaction is still there on the next cycle.
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result lost or changed");

endmodule
